>>> design/eosm_pkg.sv
// ----------------------------------------------------------------------------
// Envelope mixer package
// Shared widths, register indexes and beat payload types for the envelope
// mixer core and its helper units.
// ----------------------------------------------------------------------------
package eosm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int LEVEL_BITS    = 16;
  localparam int POS_BITS      = 21;
  localparam int FINAL_BITS    = 20;
  localparam int SEGS          = 6;
  localparam int SEG_BITS      = 3;
  localparam int SLOPE_FRAC    = 31 - LEVEL_BITS;
  localparam int GAIN_FRAC     = LEVEL_BITS - 2;
  localparam int SLOPE_BITS    = 32;

  // Breakpoint positions after the release point is made absolute.
  localparam int BP_BITS       = POS_BITS + 1;
  // Position difference between two breakpoints.
  localparam int DP_BITS       = BP_BITS + 1;

  // Slope divider operands.
  localparam int DIVIDEND_BITS = 32;
  localparam int DIVISOR_BITS  = DP_BITS - 1;

  // Shared multiplier operands and product.
  localparam int MUL_A_BITS    = 32;
  localparam int MUL_B_BITS    = FINAL_BITS + 1;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT1       = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT2       = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT3       = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT4       = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT5       = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINAL_INDEX  = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVELS_FIRST = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVELS_LAST  = 4'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [SAMPLE_BITS-1:0] new_sample;
  } pair_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic [LEVEL_BITS-1:0]         gain_level;
    logic                          segment_done;
  } mix_beat_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  value;
  } cfg_beat_t;

endpackage

>>> design/eosm_stream_if.sv
// ----------------------------------------------------------------------------
// Envelope mixer stream channel
// Valid/ready channel with a typed payload; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface eosm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/envelope_shaped_overlap_mixer_core.sv
// ----------------------------------------------------------------------------
// Envelope-shaped overlap mixer core
// Mixes a new note sample into an existing sample under a six-segment
// piecewise linear envelope, one sample pair per beat.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                       Beat
//   -------  ---  --------------------------------------------  ----------------
//   pair     in   old_sample, new_sample (Q1.23)                one sample pair
//   mix      out  mixed_sample (Q1.23), gain_level (Q2.14),     one mixed sample
//                 segment_done
//   cfg      in   index, value                                  one register write
//
// The result register loads once a pair has passed the select, multiply
// and accumulate states for each of the six segments through the one shared
// multiplier and then the mix multiply and finish states. The next pair can
// be taken the cycle after it loads. Every accepted write to a listed
// register starts a slope pass through the bit-serial divider for each of
// the six segments, bar those of zero length; no sample pair is taken during the
// pass or while a register write is offered, and further writes restart it.
// Reset is synchronous and clears the registers, the slopes and the index.
// A result waits in an output register, so a stalled mix channel holds only
// the finish of the following pair.
// ----------------------------------------------------------------------------
module envelope_shaped_overlap_mixer_core
  import eosm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1048576
) (
  input logic           clk,
  input logic           rst,
  eosm_stream_if.sink   pair,
  eosm_stream_if.source mix,
  eosm_stream_if.sink   cfg
);

  localparam logic [31:0] MAX_IDX = 32'(MAX_SAMPLES - 1);
  localparam int VAL_BITS = PROD_BITS - SLOPE_FRAC + 1;
  localparam logic signed [PROD_BITS-1:0] SEG_ROUND =
    PROD_BITS'(64'sd1 <<< (SLOPE_FRAC - 1));
  localparam logic signed [PROD_BITS-1:0] MIX_ROUND =
    PROD_BITS'(64'sd1 <<< (GAIN_FRAC - 1));
  localparam logic signed [PROD_BITS-1:0] SAMPLE_MAX =
    PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - 1;

  // The sequencer: idle, the slope pass after a register write, then the
  // per-sample segment loop and the mix.
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SL_START = 8'b0000_0010,
    S_SL_WAIT  = 8'b0000_0100,
    S_SEG_SEL  = 8'b0000_1000,
    S_SEG_MUL  = 8'b0001_0000,
    S_SEG_ACC  = 8'b0010_0000,
    S_MIX_MUL  = 8'b0100_0000,
    S_MIX_FIN  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [SEG_BITS-1:0] seg;

  // Configuration registers.
  logic signed [POS_BITS-1:0] point1_position;
  logic signed [POS_BITS-1:0] point2_position;
  logic signed [POS_BITS-1:0] point3_position;
  logic signed [POS_BITS-1:0] point4_position;
  logic signed [POS_BITS-1:0] point5_position;
  logic [FINAL_BITS-1:0]      final_index;
  logic [3*LEVEL_BITS-1:0]    levels_first_three;
  logic [2*LEVEL_BITS-1:0]    levels_last_two;

  logic signed [SLOPE_BITS-1:0] slope [SEGS];
  logic [FINAL_BITS-1:0]        sample_index;

  // Captured sample pair and running envelope maximum.
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [SAMPLE_BITS-1:0] new_r;
  logic [LEVEL_BITS-1:0]         best;

  // Segment values registered ahead of the multiply.
  logic                         cov_r;
  logic [FINAL_BITS-1:0]        off_r;
  logic [LEVEL_BITS-1:0]        base_r;
  logic [LEVEL_BITS-1:0]        lo_r;
  logic [LEVEL_BITS-1:0]        hi_r;
  logic signed [SLOPE_BITS-1:0] slope_r;
  logic                         neg_r;

  // Output register.
  logic      out_valid;
  mix_beat_t out_data;

  // Combinational helpers.
  logic [FINAL_BITS-1:0]        final_eff;
  logic signed [BP_BITS-1:0]    f_ext;
  logic signed [BP_BITS-1:0]    pa;
  logic signed [BP_BITS-1:0]    pb;
  logic [LEVEL_BITS-1:0]        va;
  logic [LEVEL_BITS-1:0]        vb;
  logic [FINAL_BITS-1:0]        pa_c;
  logic [FINAL_BITS-1:0]        pb_c;
  logic                         fwd;
  logic                         bwd;
  logic signed [LEVEL_BITS:0]   dv;
  logic signed [DP_BITS-1:0]    dp;
  logic signed [DP_BITS-1:0]    dp_neg;
  logic signed [LEVEL_BITS:0]   dv_neg;
  logic [LEVEL_BITS-1:0]        adv;
  logic [DIVISOR_BITS-1:0]      adp;
  logic [DIVIDEND_BITS-1:0]     dividend;
  logic                         div_start;
  logic                         div_done;
  logic [DIVIDEND_BITS-1:0]     quotient;
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  product;
  logic signed [PROD_BITS-1:0]  seg_rnd;
  logic signed [VAL_BITS-1:0]   seg_val;
  logic [LEVEL_BITS-1:0]        seg_lvl;
  logic signed [PROD_BITS-1:0]  mix_acc;
  logic signed [PROD_BITS-1:0]  mix_shr;
  logic signed [SAMPLE_BITS-1:0] mix_sat;
  logic                         at_end;
  logic                         out_free;
  logic                         cfg_fire;
  logic                         cfg_restart;

  function automatic logic [FINAL_BITS-1:0] clamp_end(
    input logic signed [BP_BITS-1:0] p,
    input logic [FINAL_BITS-1:0]     f
  );
    logic signed [BP_BITS-1:0] fs;
    fs = signed'(BP_BITS'(f));
    if (p[BP_BITS-1]) begin
      return '0;
    end else if (p > fs) begin
      return f;
    end else begin
      return p[FINAL_BITS-1:0];
    end
  endfunction

  // The closing breakpoint never lies beyond the sample store.
  always_comb begin
    final_eff = (32'(final_index) > MAX_IDX) ? FINAL_BITS'(MAX_IDX) : final_index;
    f_ext     = signed'(BP_BITS'(final_eff));
  end

  // Both ends of the current segment. The release point counts back from
  // the closing breakpoint.
  always_comb begin
    pa = '0;
    pb = '0;
    va = '0;
    vb = '0;
    unique case (seg)
      3'd0: begin
        pa = '0;
        va = '0;
        pb = BP_BITS'(point1_position);
        vb = levels_first_three[LEVEL_BITS-1:0];
      end
      3'd1: begin
        pa = BP_BITS'(point1_position);
        va = levels_first_three[LEVEL_BITS-1:0];
        pb = BP_BITS'(point2_position);
        vb = levels_first_three[2*LEVEL_BITS-1:LEVEL_BITS];
      end
      3'd2: begin
        pa = BP_BITS'(point2_position);
        va = levels_first_three[2*LEVEL_BITS-1:LEVEL_BITS];
        pb = BP_BITS'(point3_position);
        vb = levels_first_three[3*LEVEL_BITS-1:2*LEVEL_BITS];
      end
      3'd3: begin
        pa = BP_BITS'(point3_position);
        va = levels_first_three[3*LEVEL_BITS-1:2*LEVEL_BITS];
        pb = f_ext - BP_BITS'(point4_position);
        vb = levels_last_two[LEVEL_BITS-1:0];
      end
      3'd4: begin
        pa = f_ext - BP_BITS'(point4_position);
        va = levels_last_two[LEVEL_BITS-1:0];
        pb = BP_BITS'(point5_position);
        vb = levels_last_two[2*LEVEL_BITS-1:LEVEL_BITS];
      end
      3'd5: begin
        pa = BP_BITS'(point5_position);
        va = levels_last_two[2*LEVEL_BITS-1:LEVEL_BITS];
        pb = f_ext;
        vb = '0;
      end
      default: begin
        pa = '0;
        pb = '0;
      end
    endcase
  end

  // Slope operands: magnitudes go to the divider, the sign is applied after.
  // Half the divisor is added first so the quotient rounds to nearest.
  always_comb begin
    dv       = signed'({1'b0, vb}) - signed'({1'b0, va});
    dv_neg   = -dv;
    dp       = DP_BITS'(pb) - DP_BITS'(pa);
    dp_neg   = -dp;
    adv      = dv[LEVEL_BITS] ? dv_neg[LEVEL_BITS-1:0] : dv[LEVEL_BITS-1:0];
    adp      = dp[DP_BITS-1] ? dp_neg[DIVISOR_BITS-1:0] : dp[DIVISOR_BITS-1:0];
    dividend = DIVIDEND_BITS'({adv, {SLOPE_FRAC{1'b0}}}) + DIVIDEND_BITS'(adp >> 1);
    div_start = (state == S_SL_START) && (dp != '0);
  end

  // Coverage of the current index. Ends are clamped to the segment, and the
  // level runs from whichever clamped end has the lower index.
  always_comb begin
    pa_c = clamp_end(pa, final_eff);
    pb_c = clamp_end(pb, final_eff);
    fwd  = (pa_c < pb_c) && (sample_index >= pa_c) && (sample_index <= pb_c);
    bwd  = (pb_c < pa_c) && (sample_index >= pb_c) && (sample_index <= pa_c);
  end

  // One multiplier serves both the segment ramps and the final mix. The mix
  // operands stay selected while the result waits, so the product holds.
  always_comb begin
    if ((state == S_MIX_MUL) || (state == S_MIX_FIN)) begin
      mul_a = MUL_A_BITS'(new_r);
      mul_b = signed'(MUL_B_BITS'(best));
    end else begin
      mul_a = slope_r;
      mul_b = signed'(MUL_B_BITS'(off_r));
    end
  end

  eosm_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  eosm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (adp),
    .done     (div_done),
    .quotient (quotient)
  );

  // Segment level: round the ramp, add the base, then clamp to the span of
  // the two end levels, which only removes rounding error.
  always_comb begin
    seg_rnd = product + SEG_ROUND;
    seg_val = VAL_BITS'(seg_rnd >>> SLOPE_FRAC) + signed'(VAL_BITS'(base_r));
    if (seg_val < signed'(VAL_BITS'(lo_r))) begin
      seg_lvl = lo_r;
    end else if (seg_val > signed'(VAL_BITS'(hi_r))) begin
      seg_lvl = hi_r;
    end else begin
      seg_lvl = seg_val[LEVEL_BITS-1:0];
    end
  end

  // Mix: new times gain plus the old sample at gain scale, rounded and
  // saturated to the sample range.
  always_comb begin
    mix_acc = product + (PROD_BITS'(old_r) <<< GAIN_FRAC) + MIX_ROUND;
    mix_shr = mix_acc >>> GAIN_FRAC;
    if (mix_shr > SAMPLE_MAX) begin
      mix_sat = SAMPLE_MAX[SAMPLE_BITS-1:0];
    end else if (mix_shr < SAMPLE_MIN) begin
      mix_sat = SAMPLE_MIN[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = mix_shr[SAMPLE_BITS-1:0];
    end
    at_end   = sample_index >= final_eff;
    out_free = !out_valid || mix.ready;
  end

  // A register write offered in idle goes first; the pair waits for the
  // slope pass that the write starts.
  assign pair.ready  = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready   = (state == S_IDLE) || (state == S_SL_START) || (state == S_SL_WAIT);
  assign cfg_fire    = cfg.valid && cfg.ready;
  assign cfg_restart = cfg_fire && (cfg.data.index <= REG_LEVELS_LAST);
  assign mix.valid   = out_valid;
  assign mix.data    = out_data;

  // Configuration registers. A write with an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      point1_position    <= '0;
      point2_position    <= '0;
      point3_position    <= '0;
      point4_position    <= '0;
      point5_position    <= '0;
      final_index        <= '0;
      levels_first_three <= '0;
      levels_last_two    <= '0;
    end else if (cfg_fire) begin
      unique case (cfg.data.index)
        REG_POINT1:       point1_position    <= cfg.data.value[POS_BITS-1:0];
        REG_POINT2:       point2_position    <= cfg.data.value[POS_BITS-1:0];
        REG_POINT3:       point3_position    <= cfg.data.value[POS_BITS-1:0];
        REG_POINT4:       point4_position    <= cfg.data.value[POS_BITS-1:0];
        REG_POINT5:       point5_position    <= cfg.data.value[POS_BITS-1:0];
        REG_FINAL_INDEX:  final_index        <= cfg.data.value[FINAL_BITS-1:0];
        REG_LEVELS_FIRST: levels_first_three <= cfg.data.value[3*LEVEL_BITS-1:0];
        REG_LEVELS_LAST:  levels_last_two    <= cfg.data.value[2*LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seg          <= '0;
      sample_index <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k < SEGS; k++) begin
        slope[k] <= '0;
      end
    end else begin
      // The output register loads as the mix finishes and empties when the
      // mix channel takes the beat.
      if ((state == S_MIX_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (mix.ready) begin
        out_valid <= 1'b0;
      end

      // A write to a listed register restarts the slope pass from the first segment.
      if (cfg_restart) begin
        seg   <= '0;
        state <= S_SL_START;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (pair.valid && pair.ready) begin
              old_r <= pair.data.old_sample;
              new_r <= pair.data.new_sample;
              best  <= '0;
              seg   <= '0;
              state <= S_SEG_SEL;
            end
          end

          S_SL_START: begin
            neg_r <= dv[LEVEL_BITS] ^ dp[DP_BITS-1];
            if (dp == '0) begin
              slope[seg] <= '0;
              if (seg == SEG_BITS'(SEGS - 1)) begin
                state <= S_IDLE;
              end else begin
                seg <= seg + 1'b1;
              end
            end else begin
              state <= S_SL_WAIT;
            end
          end

          S_SL_WAIT: begin
            if (div_done) begin
              slope[seg] <= neg_r ? -signed'(quotient) : signed'(quotient);
              if (seg == SEG_BITS'(SEGS - 1)) begin
                state <= S_IDLE;
              end else begin
                seg   <= seg + 1'b1;
                state <= S_SL_START;
              end
            end
          end

          S_SEG_SEL: begin
            cov_r   <= (pa != pb) && (fwd || bwd);
            off_r   <= fwd ? (sample_index - pa_c) : (sample_index - pb_c);
            base_r  <= fwd ? va : vb;
            lo_r    <= (va < vb) ? va : vb;
            hi_r    <= (va < vb) ? vb : va;
            slope_r <= slope[seg];
            state   <= S_SEG_MUL;
          end

          S_SEG_MUL: begin
            state <= S_SEG_ACC;
          end

          S_SEG_ACC: begin
            if (cov_r && (seg_lvl > best)) begin
              best <= seg_lvl;
            end
            if (seg == SEG_BITS'(SEGS - 1)) begin
              state <= S_MIX_MUL;
            end else begin
              seg   <= seg + 1'b1;
              state <= S_SEG_SEL;
            end
          end

          S_MIX_MUL: begin
            state <= S_MIX_FIN;
          end

          S_MIX_FIN: begin
            if (out_free) begin
              out_data.mixed_sample <= mix_sat;
              out_data.gain_level   <= best;
              out_data.segment_done <= at_end;
              sample_index          <= at_end ? '0 : sample_index + 1'b1;
              state                 <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

>>> design/eosm_div.sv
// ----------------------------------------------------------------------------
// Envelope mixer slope divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eosm_div
  import eosm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_BITS);

  logic                     busy;
  logic [CNT_W-1:0]         count;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dsr;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS+1:0]  diff;

  // The partial remainder stays below the divisor, so the trial fits one
  // bit more than the divisor.
  always_comb begin
    trial = {rem, quo[DIVIDEND_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quo   <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        if (diff[DIVISOR_BITS+1]) begin
          rem <= trial[DIVISOR_BITS-1:0];
          quo <= {quo[DIVIDEND_BITS-2:0], 1'b0};
        end else begin
          rem <= diff[DIVISOR_BITS-1:0];
          quo <= {quo[DIVIDEND_BITS-2:0], 1'b1};
        end
        count <= count + 1'b1;
        if (count == CNT_W'(DIVIDEND_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> design/eosm_mul.sv
// ----------------------------------------------------------------------------
// Envelope mixer shared multiplier
// Signed multiplier with a registered product, shared by the segment
// evaluation and the final mix.
// ----------------------------------------------------------------------------
module eosm_mul
  import eosm_pkg::*;
(
  input  logic                        clk,
  input  logic signed [MUL_A_BITS-1:0] a,
  input  logic signed [MUL_B_BITS-1:0] b,
  output logic signed [PROD_BITS-1:0]  product
);

  always_ff @(posedge clk) begin
    product <= PROD_BITS'(a) * PROD_BITS'(b);
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Envelope mixer core testbench
// Drives sample pairs and register writes into the envelope mixer core,
// predicts every mixed beat from its own envelope and mix arithmetic, and
// checks the mix channel beat by beat under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import eosm_pkg::*;

  localparam int unsigned MAX_SAMPLES   = 1048576;
  localparam int unsigned RANDOM_PAIRS  = 1850;
  localparam int unsigned SETTLE_CYCLES = 30;    // settle time before registers change
  localparam int unsigned LONG_HOLD     = 300;   // long mix channel hold-off
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no beat at all

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAT_HI[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAT_LO[SAMPLE_BITS-1:0];

  // Register indexes past the last register; writes to them are dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_LOW  = REG_LEVELS_LAST + 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_HIGH = '1;

  localparam logic [CFG_INDEX_BITS-1:0] POINT_REGS [5] = '{
    REG_POINT1, REG_POINT2, REG_POINT3, REG_POINT4, REG_POINT5
  };

  // --------------------------------------------------------------------------
  // Envelope and mix predictor with the queue of mixed beats still owed.
  // It keeps its own copy of the registers, the segment slopes and the
  // running sample index.
  // --------------------------------------------------------------------------
  class envelope_mix_board;
    longint                point_pos [5];
    logic [FINAL_BITS-1:0] final_idx;
    logic [47:0]           levels_first;
    logic [31:0]           levels_last;
    logic [FINAL_BITS-1:0] idx_now;
    int                    slope [SEGS];
    longint                bp_pos [7];
    longint                bp_lvl [7];
    mix_beat_t             pending_mixes [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           ends_seen;
    int unsigned           clipped;

    function new();
      foreach (point_pos[k]) point_pos[k] = 0;
      foreach (slope[s]) slope[s] = 0;
      final_idx    = '0;
      levels_first = '0;
      levels_last  = '0;
      idx_now      = '0;
      errors       = 0;
      checked      = 0;
      ends_seen    = 0;
      clipped      = 0;
    endfunction

    function longint last_index();
      longint f;
      f = longint'(final_idx);
      return (f > MAX_SAMPLES - 1) ? longint'(MAX_SAMPLES - 1) : f;
    endfunction

    // Seven breakpoints: the fixed zero at index 0, the five configured
    // points (the fourth counted back from the end) and the closing zero.
    function void load_breakpoints();
      longint f;
      f = last_index();
      bp_pos[0] = 0;
      bp_lvl[0] = 0;
      for (int k = 0; k < 3; k++) begin
        bp_pos[k+1] = point_pos[k];
        bp_lvl[k+1] = longint'(levels_first[LEVEL_BITS*k +: LEVEL_BITS]);
      end
      bp_pos[4] = f - point_pos[3];
      bp_lvl[4] = longint'(levels_last[LEVEL_BITS-1:0]);
      bp_pos[5] = point_pos[4];
      bp_lvl[5] = longint'(levels_last[2*LEVEL_BITS-1:LEVEL_BITS]);
      bp_pos[6] = f;
      bp_lvl[6] = 0;
    endfunction

    // Slopes come from the unclamped ends, rounded to nearest with ties
    // away from zero. A zero-length segment gets a zero slope.
    function void refresh_slopes();
      longint          dv, dp;
      longint unsigned adv, adp, q;
      load_breakpoints();
      for (int s = 0; s < SEGS; s++) begin
        dv = bp_lvl[s+1] - bp_lvl[s];
        dp = bp_pos[s+1] - bp_pos[s];
        if (dp == 0) begin
          slope[s] = 0;
        end else begin
          adv = (dv < 0) ? -dv : dv;
          adp = (dp < 0) ? -dp : dp;
          q = ((adv << SLOPE_FRAC) + adp / 2) / adp;
          slope[s] = ((dv < 0) != (dp < 0)) ? -int'(q) : int'(q);
        end
      end
    endfunction

    function void write_register(cfg_beat_t b);
      case (b.index)
        REG_POINT1, REG_POINT2, REG_POINT3, REG_POINT4, REG_POINT5: begin
          point_pos[b.index] = longint'($signed(b.value[POS_BITS-1:0]));
        end
        REG_FINAL_INDEX:  final_idx    = b.value[FINAL_BITS-1:0];
        REG_LEVELS_FIRST: levels_first = b.value[47:0];
        REG_LEVELS_LAST:  levels_last  = b.value[31:0];
        default: return;
      endcase
      refresh_slopes();
    endfunction

    // Largest value of all segments covering index i, or zero.
    function longint gain_at(longint i);
      longint f, best, pa, pb, va, vb, off, base, prod, val, lo, hi;
      f    = last_index();
      best = 0;
      load_breakpoints();
      for (int s = 0; s < SEGS; s++) begin
        pa = bp_pos[s];
        pb = bp_pos[s+1];
        va = bp_lvl[s];
        vb = bp_lvl[s+1];
        if (pa == pb) continue;
        pa = (pa < 0) ? 0 : ((pa > f) ? f : pa);
        pb = (pb < 0) ? 0 : ((pb > f) ? f : pb);
        // The run starts at the clamped lower end with that end's level.
        if (pa < pb && i >= pa && i <= pb) begin
          off  = i - pa;
          base = va;
        end else if (pb < pa && i >= pb && i <= pa) begin
          off  = i - pb;
          base = vb;
        end else begin
          continue;
        end
        prod = off * longint'(slope[s]) + (longint'(1) <<< (SLOPE_FRAC - 1));
        val  = base + (prod >>> SLOPE_FRAC);
        lo   = (va < vb) ? va : vb;
        hi   = (va < vb) ? vb : va;
        if (val < lo) val = lo;
        if (val > hi) val = hi;
        if (val > best) best = val;
      end
      return best;
    endfunction

    function void note_pair(pair_beat_t b);
      longint    f, i, g, acc, r;
      mix_beat_t want;
      f   = last_index();
      i   = longint'(idx_now);
      g   = gain_at(i);
      acc = longint'($signed(b.new_sample)) * g
          + (longint'($signed(b.old_sample)) <<< GAIN_FRAC);
      r   = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      if (r > SAT_HI) begin
        r = SAT_HI;
        clipped++;
      end else if (r < SAT_LO) begin
        r = SAT_LO;
        clipped++;
      end
      want.mixed_sample = r[SAMPLE_BITS-1:0];
      want.gain_level   = g[LEVEL_BITS-1:0];
      want.segment_done = (i >= f);
      if (want.segment_done) ends_seen++;
      idx_now = want.segment_done ? '0 : idx_now + 1'b1;
      pending_mixes.push_back(want);
    endfunction

    function void check_mix(mix_beat_t got);
      mix_beat_t want;
      if (pending_mixes.size() == 0) begin
        $error("mix beat with no sample pair owed: mixed_sample %0d gain_level %0d",
               got.mixed_sample, got.gain_level);
        errors++;
        return;
      end
      want = pending_mixes.pop_front();
      checked++;
      if (got.mixed_sample !== want.mixed_sample) begin
        $error("mixed_sample: expected %0d, actual %0d", want.mixed_sample, got.mixed_sample);
        errors++;
      end
      if (got.gain_level !== want.gain_level) begin
        $error("gain_level: expected %0d, actual %0d", want.gain_level, got.gain_level);
        errors++;
      end
      if (got.segment_done !== want.segment_done) begin
        $error("segment_done: expected %0d, actual %0d", want.segment_done, got.segment_done);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block under test.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  eosm_stream_if #(.T(pair_beat_t)) pair_ch ();
  eosm_stream_if #(.T(mix_beat_t))  mix_ch ();
  eosm_stream_if #(.T(cfg_beat_t))  cfg_ch ();

  envelope_shaped_overlap_mixer_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk (clk),
    .rst (rst),
    .pair(pair_ch),
    .mix (mix_ch),
    .cfg (cfg_ch)
  );

  envelope_mix_board board;

  // Idle rates in percent of cycles, set by the stimulus as the run moves
  // through its idling modes.
  int unsigned src_idle_pct = 26;
  int unsigned rx_idle_pct  = 78;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          long_hold_pending = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned random_sent  = 0;
  int unsigned settings     = 0;

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // A register write beat. Bits above the register's width carry random
  // noise, since the block must ignore them.
  function automatic cfg_beat_t reg_beat(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] field,
                                         input int unsigned width);
    logic [CFG_DATA_BITS-1:0] keep;
    cfg_beat_t                b;
    keep    = (width >= CFG_DATA_BITS) ? '1 : ((CFG_DATA_BITS'(1) << width) - 1'b1);
    b.index = idx;
    b.value = (CFG_DATA_BITS'({$urandom, $urandom}) & ~keep) | (field & keep);
    return b;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_BITS-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  // Mostly short segments, so that many segment ends come around, with
  // the extremes now and then.
  function automatic logic [FINAL_BITS-1:0] pick_final();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return FINAL_BITS'($urandom);
      default: return FINAL_BITS'($urandom_range(63, 1));
    endcase
  endfunction

  // Positions mostly fall a little around the segment so that clamping at
  // both ends happens often; the full-range extremes are mixed in.
  function automatic int pick_position(input int unsigned f);
    case ($urandom_range(9))
      0:       return -1048576;
      1:       return 1048575;
      2:       return int'($urandom_range(2097151)) - 1048576;
      default: return int'($urandom_range(f + 8)) - 4;
    endcase
  endfunction

  // Offers a list of register writes. Valid is lowered only for random idle
  // cycles between beats and after the last beat.
  task automatic write_registers(input cfg_beat_t writes [$]);
    foreach (writes[k]) begin
      while ($urandom_range(99) < src_idle_pct) begin
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
      end
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= writes[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic offer_pairs(input pair_beat_t beats [$]);
    foreach (beats[k]) begin
      while ($urandom_range(99) < src_idle_pct) begin
        pair_ch.valid <= 1'b0;
        @(posedge clk);
      end
      pair_ch.valid <= 1'b1;
      pair_ch.data  <= beats[k];
      do @(posedge clk); while (!pair_ch.ready);
    end
    pair_ch.valid <= 1'b0;
  endtask

  // The sender waits until every owed mixed beat is back, then lets the
  // pipeline settle before registers may change.
  task automatic drain_results();
    while (board.pending_mixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Monitor. All three channels are sampled at the rising edge, before any
  // of this edge's updates land. The result check runs before the new pair
  // is noted, so a pair can never be matched against its own expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (mix_ch.valid && mix_ch.ready) board.check_mix(mix_ch.data);
      if (pair_ch.valid && pair_ch.ready) board.note_pair(pair_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) board.write_register(cfg_ch.data);
      if ((mix_ch.valid && mix_ch.ready) || (pair_ch.valid && pair_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on any channel means the
  // block has hung or lost a result.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAIL envelope_shaped_overlap_mixer_core");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. Ready is drawn at random each cycle from the current idle
  // rate. On request it holds ready low for a long counted stretch, so the
  // block fills up and has to stall the pair channel.
  // --------------------------------------------------------------------------
  initial begin
    mix_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        mix_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mix_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main stimulus.
  // --------------------------------------------------------------------------
  initial begin
    pair_beat_t            beats [$];
    cfg_beat_t             writes [$];
    int unsigned           n;
    int unsigned           phase;
    logic [FINAL_BITS-1:0] cur_final;

    board         = new();
    pair_ch.valid = 1'b0;
    pair_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    cur_final     = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: every breakpoint sits at index 0, so no segment has
    // any length, the gain is zero and each sample ends a segment.
    beats = '{};
    beats.push_back('{old_sample: S_MAX, new_sample: S_MAX});
    beats.push_back('{old_sample: S_MIN, new_sample: S_MIN});
    beats.push_back('{old_sample: '1,    new_sample: S_MAX});
    offer_pairs(beats);

    // A plain envelope over 16 samples: rise to full scale, fall, a zero-length
    // segment at the third point, a rise to a second peak and the release.
    // Full-scale gain with extreme samples saturates both ways.
    drain_results();
    writes = '{};
    writes.push_back(reg_beat(REG_FINAL_INDEX, CFG_DATA_BITS'(15), FINAL_BITS));
    writes.push_back(reg_beat(REG_POINT1, CFG_DATA_BITS'(3), POS_BITS));
    writes.push_back(reg_beat(REG_POINT2, CFG_DATA_BITS'(6), POS_BITS));
    writes.push_back(reg_beat(REG_POINT3, CFG_DATA_BITS'(6), POS_BITS));
    writes.push_back(reg_beat(REG_POINT4, CFG_DATA_BITS'(4), POS_BITS));
    writes.push_back(reg_beat(REG_POINT5, CFG_DATA_BITS'(13), POS_BITS));
    writes.push_back(reg_beat(REG_LEVELS_FIRST, {16'h1234, 16'h4000, 16'hFFFF}, 48));
    writes.push_back(reg_beat(REG_LEVELS_LAST,
                              CFG_DATA_BITS'({16'h8000, 16'h4000}), 32));
    write_registers(writes);
    settings++;
    beats = '{};
    for (int k = 0; k < 16; k++) begin
      case (k % 4)
        0:       beats.push_back('{old_sample: S_MAX, new_sample: S_MAX});
        1:       beats.push_back('{old_sample: S_MIN, new_sample: S_MIN});
        2:       beats.push_back('{old_sample: '0,    new_sample: S_MAX});
        default: beats.push_back('{old_sample: '1,    new_sample: S_MIN});
      endcase
    end
    offer_pairs(beats);

    // Ends clamped at both sides: the first segment collapses to nothing
    // after clamping, others run past the segment or backwards, and the
    // release point lands far beyond the end. Writes to unused indexes
    // must leave everything untouched.
    drain_results();
    writes = '{};
    writes.push_back(reg_beat(REG_FINAL_INDEX, CFG_DATA_BITS'(10), FINAL_BITS));
    writes.push_back(reg_beat(REG_POINT1, CFG_DATA_BITS'(-5), POS_BITS));
    writes.push_back(reg_beat(REG_POINT2, CFG_DATA_BITS'(20), POS_BITS));
    writes.push_back(reg_beat(REG_POINT3, CFG_DATA_BITS'(-1048576), POS_BITS));
    writes.push_back(reg_beat(REG_POINT4, CFG_DATA_BITS'(-1048576), POS_BITS));
    writes.push_back(reg_beat(REG_POINT5, CFG_DATA_BITS'(1048575), POS_BITS));
    writes.push_back(reg_beat(REG_LEVELS_FIRST, {16'h2000, 16'h3000, 16'hFFFF}, 48));
    writes.push_back(reg_beat(REG_LEVELS_LAST,
                              CFG_DATA_BITS'({16'h0001, 16'h7FFF}), 32));
    writes.push_back(reg_beat(REG_NONE_LOW, '1, CFG_DATA_BITS));
    writes.push_back(reg_beat(REG_NONE_HIGH, '1, CFG_DATA_BITS));
    write_registers(writes);
    settings++;
    beats = '{};
    repeat (4) beats.push_back('{old_sample: pick_sample(), new_sample: pick_sample()});
    offer_pairs(beats);

    // The index now stands past a lowered final index, so the next sample
    // counts as the last one and the index wraps.
    drain_results();
    writes = '{};
    writes.push_back(reg_beat(REG_FINAL_INDEX, CFG_DATA_BITS'(2), FINAL_BITS));
    write_registers(writes);
    settings++;
    cur_final = FINAL_BITS'(2);
    beats = '{};
    repeat (2) beats.push_back('{old_sample: pick_sample(), new_sample: pick_sample()});
    offer_pairs(beats);

    // Random phases: each one drains, rewrites a random subset of the
    // registers and then streams a run of random pairs. The idling mode
    // moves from a slow receiver to a slow sender to no idling at all.
    phase = 0;
    while (random_sent < RANDOM_PAIRS) begin
      if (random_sent < RANDOM_PAIRS / 3) begin
        src_idle_pct = 26;
        rx_idle_pct  = 78;
      end else if (random_sent < 2 * RANDOM_PAIRS / 3) begin
        src_idle_pct = 78;
        rx_idle_pct  = 26;
      end else begin
        src_idle_pct = 0;
        rx_idle_pct  = 0;
      end

      drain_results();
      writes = '{};
      if ($urandom_range(2) == 0) begin
        cur_final = pick_final();
        writes.push_back(reg_beat(REG_FINAL_INDEX, CFG_DATA_BITS'(cur_final), FINAL_BITS));
      end
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(2) == 0) begin
          writes.push_back(reg_beat(POINT_REGS[k],
                                    CFG_DATA_BITS'(pick_position(32'(cur_final))),
                                    POS_BITS));
        end
      end
      if ($urandom_range(2) == 0) begin
        writes.push_back(reg_beat(REG_LEVELS_FIRST,
                                  {pick_level(), pick_level(), pick_level()}, 48));
      end
      if ($urandom_range(2) == 0) begin
        writes.push_back(reg_beat(REG_LEVELS_LAST,
                                  CFG_DATA_BITS'({pick_level(), pick_level()}), 32));
      end
      if ($urandom_range(7) == 0) begin
        writes.push_back(reg_beat(CFG_INDEX_BITS'($urandom_range(REG_NONE_HIGH,
                                                                 REG_NONE_LOW)),
                                  CFG_DATA_BITS'($urandom), CFG_DATA_BITS));
      end
      if (writes.size() != 0) begin
        write_registers(writes);
        settings++;
      end

      // Now and then the receiver holds off for a long time while this
      // phase keeps offering pairs, which backs the block up.
      n = $urandom_range(90, 10);
      if (phase % 12 == 3) begin
        long_hold_pending = 1'b1;
        n = 60;
      end
      beats = '{};
      repeat (n) beats.push_back('{old_sample: pick_sample(), new_sample: pick_sample()});
      offer_pairs(beats);
      random_sent += n;
      phase++;
    end

    drain_results();

    $display("Checked %0d mixed samples over %0d register settings in %0d random phases.",
             board.checked, settings, phase);
    $display("Segment ends seen: %0d, saturated mixes: %0d, mismatches: %0d.",
             board.ends_seen, board.clipped, board.errors);
    if (board.errors == 0) begin
      $display("PASS envelope_shaped_overlap_mixer_core");
    end else begin
      $display("FAIL envelope_shaped_overlap_mixer_core");
    end
    $finish;
  end

endmodule
